// ===== hw/rtl/cbmm_pkg.sv =====
// cbmm_pkg: address map, action codes and pipeline types of the main cpu bus decoder
// no dependencies; used by cpu_bus_memory_map

package cbmm_pkg;

  // memory geometry
  localparam int unsigned ROM_DEPTH = 49152;
  localparam int unsigned ROM_AW    = 16;
  // one shared store for all rams, indexed by address - c000 (c000..ebff)
  localparam int unsigned RAM_DEPTH = 11264;
  localparam int unsigned RAM_AW    = 14;

  // configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;
  localparam logic [1:0] CFG_DIP_A = 2'd0;
  localparam logic [1:0] CFG_DIP_B = 2'd1;
  localparam logic [1:0] CFG_DIP_C = 2'd2;

  // address map
  localparam logic [15:0] ADDR_ROM_TOP   = 16'hBFFF;
  localparam logic [15:0] ADDR_RAM_BASE  = 16'hC000;
  localparam logic [15:0] ADDR_PAL_BASE  = 16'hD800;
  localparam logic [15:0] ADDR_PAL_TOP   = 16'hDDFF;
  localparam logic [15:0] ADDR_BG_BASE   = 16'hE000;
  localparam logic [15:0] ADDR_BG_TOP    = 16'hE7FF;
  localparam logic [15:0] ADDR_SPR_TOP   = 16'hEBFF;
  localparam logic [15:0] ADDR_SCROLL0   = 16'hEC00;
  localparam logic [15:0] ADDR_SCROLL1   = 16'hEC01;
  localparam logic [15:0] ADDR_SCROLL2   = 16'hEC02;
  localparam logic [15:0] ADDR_P1_X      = 16'hF800;
  localparam logic [15:0] ADDR_P1_Y      = 16'hF801;
  localparam logic [15:0] ADDR_COIN      = 16'hF802;
  localparam logic [15:0] ADDR_P1_BTN    = 16'hF803;
  localparam logic [15:0] ADDR_P2_X      = 16'hF810;
  localparam logic [15:0] ADDR_P2_Y      = 16'hF811;
  localparam logic [15:0] ADDR_P2_BTN    = 16'hF813;
  localparam logic [15:0] ADDR_SOUND     = 16'hF820;
  localparam logic [15:0] ADDR_DIP_A     = 16'hF840;
  localparam logic [15:0] ADDR_DIP_B     = 16'hF850;
  localparam logic [15:0] ADDR_DIP_C     = 16'hF870;

  localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;
  localparam logic [7:0] TRACK_STEP    = 8'd4;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SRC_IMM = 2'd0,
    SRC_ROM = 2'd1,
    SRC_RAM = 2'd2
  } rd_src_e;

  // result fields carried from the access stage to the output register
  typedef struct packed {
    rd_src_e     src;
    logic [7:0]  imm;
    logic        pal;
    logic        bgw;
    logic [9:0]  bgi;
    logic        nmi;
    logic [7:0]  snd;
    logic        halt;
  } stage_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        pal;
    logic        bgw;
    logic [9:0]  bgi;
    logic        nmi;
    logic [7:0]  snd;
    logic        halt;
  } result_t;

  function automatic logic [7:0] move_axis(logic [7:0] v, logic minus, logic plus);
    logic [7:0] r;
    r = v;
    if (minus) r = r - TRACK_STEP;
    if (plus)  r = r + TRACK_STEP;
    return r;
  endfunction

endpackage

// ===== hw/rtl/cbmm_ram.sv =====
// cbmm_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies

module cbmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cpu_bus_memory_map.sv =====
// Main cpu bus decoder with program rom and on-chip rams. One transfer per clock is taken
// unless clearing or an output stall holds in_ready_o low. Its result is registered in the
// access stage, then in the output register. After reset a clearing pass zeroes the shared
// ram store one entry a cycle, with in_ready_o low; the program rom is not cleared. The user
// must write dip banks over the apb port only while idle; the block does not enforce this.
// cpu_bus_memory_map: top level, address decode, registers and result pipeline
// depends on cbmm_pkg and cbmm_ram

module cpu_bus_memory_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [15:0]                  address_i,
  input  logic [7:0]                   write_data_i,
  input  logic [7:0]                   coin_bits_i,
  input  logic [7:0]                   player1_buttons_i,
  input  logic [7:0]                   player2_buttons_i,
  input  logic [7:0]                   sound_reply_i,
  input  logic [3:0]                   player1_directions_i,
  input  logic [3:0]                   player2_directions_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   read_data_o,
  output logic                         palette_changed_o,
  output logic                         bg_cell_written_o,
  output logic [9:0]                   bg_cell_index_o,
  output logic                         sound_nmi_o,
  output logic [7:0]                   sound_command_o,
  output logic                         sub_cpu_halted_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbmm_pkg::CFG_AW-1:0]  paddr,
  input  logic [cbmm_pkg::CFG_DW-1:0]  pwdata,
  output logic [cbmm_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  localparam logic [cbmm_pkg::RAM_AW-1:0] ClrLast =
    cbmm_pkg::RAM_AW'(cbmm_pkg::RAM_DEPTH - 1);

  localparam logic [1:0] CFG_DIP_A_IDX = cbmm_pkg::CFG_DIP_A;
  localparam logic [1:0] CFG_DIP_B_IDX = cbmm_pkg::CFG_DIP_B;
  localparam logic [1:0] CFG_DIP_C_IDX = cbmm_pkg::CFG_DIP_C;

  cbmm_pkg::action_e act;
  logic              accept;
  logic              s1_adv;
  logic              cfg_we;

  logic              clr_busy_q, clr_busy_d;
  logic [cbmm_pkg::RAM_AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [7:0] dip_q [3];
  logic [7:0] scroll_q [3];
  logic [7:0] scroll_d [3];
  logic [7:0] track_q [4];
  logic [7:0] track_d [4];
  logic [7:0] latch_q, latch_d;
  logic       halt_q, halt_d;

  logic              s1_valid_q, s1_valid_d;
  cbmm_pkg::stage_t  s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  cbmm_pkg::result_t out_q, out_d;

  logic is_rom, is_ram, is_pal, is_bg;

  logic                        rom_we, rom_re;
  logic [7:0]                  rom_rdata;
  logic                        ram_we, ram_re;
  logic [cbmm_pkg::RAM_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_rdata;

  assign act    = cbmm_pkg::action_e'(action_i);
  assign s1_adv = !out_valid_q || out_ready_i;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept = in_valid_i && in_ready_o;

  // address decode
  assign is_rom = address_i <= cbmm_pkg::ADDR_ROM_TOP;
  assign is_ram = (address_i >= cbmm_pkg::ADDR_RAM_BASE) &&
                  ((address_i <= cbmm_pkg::ADDR_PAL_TOP) ||
                   ((address_i >= cbmm_pkg::ADDR_BG_BASE) &&
                    (address_i <= cbmm_pkg::ADDR_SPR_TOP)));
  assign is_pal = (address_i >= cbmm_pkg::ADDR_PAL_BASE) &&
                  (address_i <= cbmm_pkg::ADDR_PAL_TOP);
  assign is_bg  = (address_i >= cbmm_pkg::ADDR_BG_BASE) &&
                  (address_i <= cbmm_pkg::ADDR_BG_TOP);

  // memory ports
  assign rom_we = accept && (act == cbmm_pkg::ACT_LOAD) && is_rom;
  assign rom_re = accept && (act == cbmm_pkg::ACT_READ) && is_rom;
  assign ram_re = accept && (act == cbmm_pkg::ACT_READ) && is_ram;
  assign ram_we = clr_busy_q || (accept && (act == cbmm_pkg::ACT_WRITE) && is_ram);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : address_i[cbmm_pkg::RAM_AW-1:0];
  assign ram_wdata = clr_busy_q ? 8'h00 : write_data_i;

  cbmm_ram #(
    .Width (8),
    .Depth (cbmm_pkg::ROM_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .waddr_i (address_i[cbmm_pkg::ROM_AW-1:0]),
    .wdata_i (write_data_i),
    .re_i    (rom_re),
    .raddr_i (address_i[cbmm_pkg::ROM_AW-1:0]),
    .rdata_o (rom_rdata)
  );

  cbmm_ram #(
    .Width (8),
    .Depth (cbmm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (address_i[cbmm_pkg::RAM_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // clearing pass
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ClrLast) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // access stage
  always_comb begin
    scroll_d = scroll_q;
    track_d  = track_q;
    latch_d  = latch_q;
    halt_d   = halt_q;
    s1_d     = '0;
    s1_d.src = cbmm_pkg::SRC_IMM;
    s1_d.imm = cbmm_pkg::BYTE_UNMAPPED;
    if (accept) begin
      unique case (act)
        cbmm_pkg::ACT_READ: begin
          if (is_rom) begin
            s1_d.src = cbmm_pkg::SRC_ROM;
          end else if (is_ram) begin
            s1_d.src = cbmm_pkg::SRC_RAM;
          end else begin
            unique case (address_i)
              cbmm_pkg::ADDR_SCROLL0: s1_d.imm = scroll_q[0];
              cbmm_pkg::ADDR_SCROLL1: s1_d.imm = scroll_q[1];
              cbmm_pkg::ADDR_SCROLL2: s1_d.imm = scroll_q[2];
              cbmm_pkg::ADDR_P1_X:    s1_d.imm = track_q[0];
              cbmm_pkg::ADDR_P1_Y:    s1_d.imm = track_q[1];
              cbmm_pkg::ADDR_COIN:    s1_d.imm = coin_bits_i;
              cbmm_pkg::ADDR_P1_BTN:  s1_d.imm = player1_buttons_i;
              cbmm_pkg::ADDR_P2_X:    s1_d.imm = track_q[2];
              cbmm_pkg::ADDR_P2_Y:    s1_d.imm = track_q[3];
              cbmm_pkg::ADDR_P2_BTN:  s1_d.imm = player2_buttons_i;
              cbmm_pkg::ADDR_SOUND:   s1_d.imm = sound_reply_i;
              cbmm_pkg::ADDR_DIP_A:   s1_d.imm = dip_q[0];
              cbmm_pkg::ADDR_DIP_B:   s1_d.imm = dip_q[1];
              cbmm_pkg::ADDR_DIP_C:   s1_d.imm = dip_q[2];
              default:                s1_d.imm = cbmm_pkg::BYTE_UNMAPPED;
            endcase
          end
        end
        cbmm_pkg::ACT_WRITE: begin
          s1_d.pal = is_pal;
          s1_d.bgw = is_bg;
          s1_d.bgi = is_bg ? address_i[10:1] : 10'd0;
          unique case (address_i)
            cbmm_pkg::ADDR_SCROLL0: scroll_d[0] = write_data_i;
            cbmm_pkg::ADDR_SCROLL1: scroll_d[1] = write_data_i;
            cbmm_pkg::ADDR_SCROLL2: scroll_d[2] = write_data_i;
            cbmm_pkg::ADDR_P1_X:    track_d[0] = write_data_i;
            cbmm_pkg::ADDR_P1_Y:    track_d[1] = write_data_i;
            cbmm_pkg::ADDR_P2_X:    track_d[2] = write_data_i;
            cbmm_pkg::ADDR_P2_Y:    track_d[3] = write_data_i;
            cbmm_pkg::ADDR_SOUND: begin
              latch_d  = write_data_i;
              s1_d.nmi = 1'b1;
            end
            cbmm_pkg::ADDR_DIP_A:   halt_d = !write_data_i[0];
            default: ;
          endcase
        end
        cbmm_pkg::ACT_LOAD: ;
        cbmm_pkg::ACT_TICK: begin
          track_d[0] = cbmm_pkg::move_axis(track_q[0], player1_directions_i[0],
                                           player1_directions_i[1]);
          track_d[1] = cbmm_pkg::move_axis(track_q[1], player1_directions_i[2],
                                           player1_directions_i[3]);
          track_d[2] = cbmm_pkg::move_axis(track_q[2], player2_directions_i[0],
                                           player2_directions_i[1]);
          track_d[3] = cbmm_pkg::move_axis(track_q[3], player2_directions_i[2],
                                           player2_directions_i[3]);
        end
        default: ;
      endcase
    end
    s1_d.snd  = latch_d;
    s1_d.halt = halt_d;
  end

  // pipeline control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // result merge with memory read data
  always_comb begin
    out_d.pal  = s1_q.pal;
    out_d.bgw  = s1_q.bgw;
    out_d.bgi  = s1_q.bgi;
    out_d.nmi  = s1_q.nmi;
    out_d.snd  = s1_q.snd;
    out_d.halt = s1_q.halt;
    unique case (s1_q.src)
      cbmm_pkg::SRC_ROM: out_d.rdata = rom_rdata;
      cbmm_pkg::SRC_RAM: out_d.rdata = ram_rdata;
      default:           out_d.rdata = s1_q.imm;
    endcase
  end

  // configuration port
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      CFG_DIP_A_IDX: prdata = cbmm_pkg::CFG_DW'(dip_q[0]);
      CFG_DIP_B_IDX: prdata = cbmm_pkg::CFG_DW'(dip_q[1]);
      CFG_DIP_C_IDX: prdata = cbmm_pkg::CFG_DW'(dip_q[2]);
      default:       prdata = '0;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      latch_q     <= 8'h00;
      halt_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        scroll_q[i] <= 8'h00;
        dip_q[i]    <= 8'hFF;
      end
      for (int i = 0; i < 4; i++) begin
        track_q[i] <= 8'h00;
      end
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      latch_q     <= latch_d;
      halt_q      <= halt_d;
      scroll_q    <= scroll_d;
      track_q     <= track_d;
      if (cfg_we) begin
        unique case (paddr[3:2])
          CFG_DIP_A_IDX: dip_q[0] <= pwdata[7:0];
          CFG_DIP_B_IDX: dip_q[1] <= pwdata[7:0];
          CFG_DIP_C_IDX: dip_q[2] <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_q.rdata;
  assign palette_changed_o = out_q.pal;
  assign bg_cell_written_o = out_q.bgw;
  assign bg_cell_index_o   = out_q.bgi;
  assign sound_nmi_o       = out_q.nmi;
  assign sound_command_o   = out_q.snd;
  assign sub_cpu_halted_o  = out_q.halt;

  // checks
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("transfer accepted during ram clearing");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while access stage is stalled");

  a_side_effects_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({palette_changed_o, bg_cell_written_o, sound_nmi_o}))
    else $error("more than one write side effect");

  a_bg_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !bg_cell_written_o) |-> (bg_cell_index_o == 10'd0))
    else $error("background index without background write");

  a_halt_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (act == cbmm_pkg::ACT_WRITE) && (address_i == cbmm_pkg::ADDR_DIP_A))
    |=> (halt_q == !$past(write_data_i[0])))
    else $error("halt level not updated by write");

endmodule
